>>> sv/qau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg: shared types and constants for the quaternion attitude unit
// Fixed-point formats, opcodes and the input/result word structs.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int QUAT_FRAC_BITS = 30;
  localparam int VEC_FRAC_BITS  = 16;

  localparam logic [2:0] OP_INTEG = 3'd0;
  localparam logic [2:0] OP_MUL   = 3'd1;
  localparam logic [2:0] OP_ROT   = 3'd2;
  localparam logic [2:0] OP_CONJ  = 3'd3;
  localparam logic [2:0] OP_NORM  = 3'd4;
  localparam logic [2:0] OP_LOAD  = 3'd5;

  localparam logic signed [31:0] QONE = 32'sd1 <<< QUAT_FRAC_BITS;
  localparam logic signed [31:0] DONE = 32'sd1 <<< (VEC_FRAC_BITS + 1);

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] opd_w;
    logic signed [31:0] opd_x;
    logic signed [31:0] opd_y;
    logic signed [31:0] opd_z;
  } qau_in_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               flag;
  } qau_out_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7fffffff;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [71:0] v);
    return (v > 72'sd2147483647) || (v < -72'sd2147483648);
  endfunction

endpackage

>>> sv/qau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_div: restoring divider / square root unit
// Bit-serial unsigned divide (64 / 32) or integer square root, one bit a cycle.
// ----------------------------------------------------------------------------
module qau_div
  import qau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        sqrt_mode,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [63:0] quo
);

  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] n_r, n_nxt;
  logic [65:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic        sq_r, sq_nxt;
  logic [31:0] d_r, d_nxt;
  logic [65:0] trial;
  logic [65:0] sh;

  assign busy = (cnt_r != 7'd0);
  assign quo  = q_r;

  // one quotient or root bit per cycle
  always_comb begin
    cnt_nxt = cnt_r; n_nxt = n_r; rem_nxt = rem_r; q_nxt = q_r;
    sq_nxt = sq_r; d_nxt = d_r;
    sh = '0; trial = '0;
    if (start) begin
      cnt_nxt = sqrt_mode ? 7'd32 : 7'd64;
      n_nxt = num; rem_nxt = '0; q_nxt = '0; sq_nxt = sqrt_mode; d_nxt = den;
    end else if (busy) begin
      cnt_nxt = cnt_r - 7'd1;
      if (sq_r) begin
        sh = {rem_r[63:0], n_r[63:62]};
        trial = {q_r[63:0], 2'b01};
        n_nxt = {n_r[61:0], 2'b00};
      end else begin
        sh = {rem_r[64:0], n_r[63]};
        trial = {34'd0, d_r};
        n_nxt = {n_r[62:0], 1'b0};
      end
      if (sh >= trial) begin
        rem_nxt = sh - trial; q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh; q_nxt = {q_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    n_r <= n_nxt; rem_r <= rem_nxt; q_r <= q_nxt; sq_r <= sq_nxt; d_r <= d_nxt;
  end

endmodule

>>> sv/quaternion_attitude_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_attitude_unit: orientation quaternion integrator
// Holds one Q2.30 quaternion and applies one operation per input word.
// ----------------------------------------------------------------------------
// One input word at a time. A word is taken when the unit is idle; its result
// word appears after a sequence through one shared 32x32 multiplier with four
// accumulators (one product a cycle): integrate and multiply take 16 products
// plus 4 rounding steps, rotate takes 15 products in two passes, normalize
// takes 4 squares, a root and four divides, and conjugate, load and unused
// codes go straight to the result word. in_stall stays high from acceptance
// until the result word has been taken; the quaternion resets to identity.
module quaternion_attitude_unit
  import qau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output qau_out_t out_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAC   = 4'd1;
  localparam logic [3:0] S_RND   = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_DIVGO = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_ROOTW = 4'd8;

  logic [3:0] st_r, st_nxt;
  logic signed [31:0] q_r [4];
  logic signed [31:0] q_nxt [4];
  logic signed [31:0] p_r [4];
  logic signed [31:0] p_nxt [4];
  logic signed [31:0] t_r [3];
  logic signed [31:0] t_nxt [3];
  logic signed [31:0] rot_r [3];
  logic signed [31:0] rot_nxt [3];
  logic signed [71:0] acc_r [4];
  logic signed [71:0] acc_nxt [4];
  logic [2:0] op_r, op_nxt;
  logic [4:0] k_r, k_nxt;
  logic       pass_r, pass_nxt;
  logic       flag_r, flag_nxt;
  logic [31:0] len_r, len_nxt;

  // product term selection
  logic signed [31:0] ma, mb;
  logic [1:0] tgt;
  logic       neg, mvalid;
  logic signed [63:0] prod;
  logic signed [71:0] rnd;
  logic [5:0] shamt;

  // divider
  logic        dv_start, dv_sqrt, dv_busy;
  logic [63:0] dv_num, dv_quo;
  logic [31:0] dv_den;
  logic [31:0] mag;
  logic signed [71:0] qv;

  qau_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .sqrt_mode(dv_sqrt),
    .num(dv_num), .den(dv_den), .busy(dv_busy), .quo(dv_quo)
  );

  // Hamilton product / rotation term table, step k
  always_comb begin
    ma = '0; mb = '0; tgt = 2'd0; neg = 1'b0; mvalid = 1'b1;
    if (op_r == OP_ROT && !pass_r) begin
      case (k_r)
        5'd0: begin ma = q_r[2]; mb = p_r[3]; tgt = 2'd0; end
        5'd1: begin ma = q_r[3]; mb = p_r[2]; tgt = 2'd0; neg = 1'b1; end
        5'd2: begin ma = q_r[3]; mb = p_r[1]; tgt = 2'd1; end
        5'd3: begin ma = q_r[1]; mb = p_r[3]; tgt = 2'd1; neg = 1'b1; end
        5'd4: begin ma = q_r[1]; mb = p_r[2]; tgt = 2'd2; end
        5'd5: begin ma = q_r[2]; mb = p_r[1]; tgt = 2'd2; neg = 1'b1; end
        default: mvalid = 1'b0;
      endcase
    end else if (op_r == OP_ROT) begin
      case (k_r)
        5'd0: begin ma = q_r[0]; mb = t_r[0]; tgt = 2'd0; end
        5'd1: begin ma = q_r[0]; mb = t_r[1]; tgt = 2'd1; end
        5'd2: begin ma = q_r[0]; mb = t_r[2]; tgt = 2'd2; end
        5'd3: begin ma = q_r[2]; mb = t_r[2]; tgt = 2'd0; end
        5'd4: begin ma = q_r[3]; mb = t_r[1]; tgt = 2'd0; neg = 1'b1; end
        5'd5: begin ma = q_r[3]; mb = t_r[0]; tgt = 2'd1; end
        5'd6: begin ma = q_r[1]; mb = t_r[2]; tgt = 2'd1; neg = 1'b1; end
        5'd7: begin ma = q_r[1]; mb = t_r[1]; tgt = 2'd2; end
        5'd8: begin ma = q_r[2]; mb = t_r[0]; tgt = 2'd2; neg = 1'b1; end
        default: mvalid = 1'b0;
      endcase
    end else if (st_r == S_SQ) begin
      ma = q_r[k_r[1:0]]; mb = q_r[k_r[1:0]]; tgt = 2'd0;
    end else begin
      case (k_r)
        5'd0:  begin ma = q_r[0]; mb = p_r[0]; tgt = 2'd0; end
        5'd1:  begin ma = q_r[1]; mb = p_r[1]; tgt = 2'd0; neg = 1'b1; end
        5'd2:  begin ma = q_r[2]; mb = p_r[2]; tgt = 2'd0; neg = 1'b1; end
        5'd3:  begin ma = q_r[3]; mb = p_r[3]; tgt = 2'd0; neg = 1'b1; end
        5'd4:  begin ma = q_r[0]; mb = p_r[1]; tgt = 2'd1; end
        5'd5:  begin ma = q_r[1]; mb = p_r[0]; tgt = 2'd1; end
        5'd6:  begin ma = q_r[2]; mb = p_r[3]; tgt = 2'd1; end
        5'd7:  begin ma = q_r[3]; mb = p_r[2]; tgt = 2'd1; neg = 1'b1; end
        5'd8:  begin ma = q_r[0]; mb = p_r[2]; tgt = 2'd2; end
        5'd9:  begin ma = q_r[1]; mb = p_r[3]; tgt = 2'd2; neg = 1'b1; end
        5'd10: begin ma = q_r[2]; mb = p_r[0]; tgt = 2'd2; end
        5'd11: begin ma = q_r[3]; mb = p_r[1]; tgt = 2'd2; end
        5'd12: begin ma = q_r[0]; mb = p_r[3]; tgt = 2'd3; end
        5'd13: begin ma = q_r[1]; mb = p_r[2]; tgt = 2'd3; end
        5'd14: begin ma = q_r[2]; mb = p_r[1]; tgt = 2'd3; neg = 1'b1; end
        5'd15: begin ma = q_r[3]; mb = p_r[0]; tgt = 2'd3; end
        default: mvalid = 1'b0;
      endcase
    end
  end

  assign prod = ma * mb;

  // rounding shift of the current accumulator
  always_comb begin
    case (op_r)
      OP_INTEG: shamt = 6'(VEC_FRAC_BITS + 1);
      OP_ROT:   shamt = pass_r ? 6'(QUAT_FRAC_BITS) : 6'(QUAT_FRAC_BITS - 1);
      default:  shamt = 6'(QUAT_FRAC_BITS);
    endcase
    rnd = (acc_r[k_r[1:0]] + (72'sd1 <<< (shamt - 6'd1))) >>> shamt;
  end

  // normalize component: |q| << (F-1), divided by len with half-up rounding
  assign mag = q_r[k_r[1:0]][31] ? 32'(-q_r[k_r[1:0]]) : q_r[k_r[1:0]];
  assign qv  = q_r[k_r[1:0]][31] ? -$signed({8'd0, dv_quo}) : $signed({8'd0, dv_quo});

  // sequencer
  always_comb begin
    st_nxt = st_r; op_nxt = op_r; k_nxt = k_r; pass_nxt = pass_r; flag_nxt = flag_r;
    len_nxt = len_r;
    dv_start = 1'b0; dv_sqrt = 1'b0; dv_num = '0; dv_den = len_r;
    for (int i = 0; i < 4; i++) begin
      q_nxt[i] = q_r[i]; p_nxt[i] = p_r[i]; acc_nxt[i] = acc_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      t_nxt[i] = t_r[i]; rot_nxt[i] = rot_r[i];
    end
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data.op; k_nxt = '0; pass_nxt = 1'b0; flag_nxt = 1'b0;
          p_nxt[0] = (in_data.op == OP_INTEG) ? DONE : in_data.opd_w;
          p_nxt[1] = in_data.opd_x; p_nxt[2] = in_data.opd_y; p_nxt[3] = in_data.opd_z;
          for (int i = 0; i < 4; i++) acc_nxt[i] = '0;
          for (int i = 0; i < 3; i++) rot_nxt[i] = '0;
          case (in_data.op)
            OP_INTEG, OP_MUL, OP_ROT: st_nxt = S_MAC;
            OP_NORM: st_nxt = S_SQ;
            OP_CONJ: begin
              for (int i = 1; i < 4; i++) begin
                q_nxt[i] = sat32(-72'(q_r[i]));
                if (q_r[i] == 32'sh80000000) flag_nxt = 1'b1;
              end
              st_nxt = S_OUT;
            end
            OP_LOAD: begin
              q_nxt[0] = in_data.opd_w; q_nxt[1] = in_data.opd_x;
              q_nxt[2] = in_data.opd_y; q_nxt[3] = in_data.opd_z;
              st_nxt = S_OUT;
            end
            default: st_nxt = S_OUT;
          endcase
        end
      end
      S_MAC: begin
        if (mvalid) begin
          acc_nxt[tgt] = acc_r[tgt] + (neg ? -72'(prod) : 72'(prod));
          k_nxt = k_r + 5'd1;
        end else begin
          k_nxt = '0; st_nxt = S_RND;
        end
      end
      S_RND: begin
        // round and saturate one accumulator a cycle
        if (op_r == OP_ROT && !pass_r) begin
          t_nxt[k_r[1:0]] = sat32(rnd);
          if (ovf32(rnd)) flag_nxt = 1'b1;
        end else if (op_r == OP_ROT) begin
          rot_nxt[k_r[1:0]] = sat32(72'(p_r[k_r[1:0] + 2'd1]) + rnd);
          if (ovf32(72'(p_r[k_r[1:0] + 2'd1]) + rnd)) flag_nxt = 1'b1;
        end else begin
          q_nxt[k_r[1:0]] = sat32(rnd);
          if (ovf32(rnd)) flag_nxt = 1'b1;
        end
        k_nxt = k_r + 5'd1;
        if ((op_r == OP_ROT && k_r == 5'd2) || k_r == 5'd3) begin
          k_nxt = '0;
          if (op_r == OP_ROT && !pass_r) begin
            pass_nxt = 1'b1; st_nxt = S_MAC;
            for (int i = 0; i < 4; i++) acc_nxt[i] = '0;
          end else st_nxt = S_OUT;
        end
      end
      S_SQ: begin
        acc_nxt[0] = acc_r[0] + 72'(prod);
        k_nxt = k_r + 5'd1;
        if (k_r == 5'd3) st_nxt = S_ROOT;
      end
      S_ROOT: begin
        dv_start = 1'b1; dv_sqrt = 1'b1; dv_num = acc_r[0][65:2];
        st_nxt = S_ROOTW; k_nxt = '0;
      end
      S_ROOTW: begin
        if (!dv_busy) begin
          len_nxt = dv_quo[31:0];
          if (dv_quo == 64'd0) begin
            flag_nxt = 1'b1; st_nxt = S_OUT;
          end else st_nxt = S_DIVGO;
        end
      end
      S_DIVGO: begin
        dv_start = 1'b1;
        dv_num = ({32'd0, mag} << (QUAT_FRAC_BITS - 1)) + {33'd0, len_r[31:1]};
        st_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (!dv_busy) begin
          q_nxt[k_r[1:0]] = sat32(qv);
          if (ovf32(qv)) flag_nxt = 1'b1;
          k_nxt = k_r + 5'd1;
          st_nxt = (k_r == 5'd3) ? S_OUT : S_DIVGO;
        end
      end
      S_OUT: begin
        if (!out_stall) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      q_r[0] <= QONE; q_r[1] <= '0; q_r[2] <= '0; q_r[3] <= '0;
    end else begin
      st_r <= st_nxt;
      for (int i = 0; i < 4; i++) q_r[i] <= q_nxt[i];
    end
    op_r <= op_nxt; k_r <= k_nxt; pass_r <= pass_nxt; flag_r <= flag_nxt; len_r <= len_nxt;
    for (int i = 0; i < 4; i++) begin
      p_r[i] <= p_nxt[i]; acc_r[i] <= acc_nxt[i];
    end
    for (int i = 0; i < 3; i++) begin
      t_r[i] <= t_nxt[i]; rot_r[i] <= rot_nxt[i];
    end
  end

  // result word
  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_data.quat_w = q_r[0];
  assign out_data.quat_x = q_r[1];
  assign out_data.quat_y = q_r[2];
  assign out_data.quat_z = q_r[3];
  assign out_data.rot_x  = rot_r[0];
  assign out_data.rot_y  = rot_r[1];
  assign out_data.rot_z  = rot_r[2];
  assign out_data.flag   = flag_r;

  // checks
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result shown while input open");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_rot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && op_r != OP_ROT |-> rot_r[0] == '0 && rot_r[2] == '0)
    else $error("rot fields not cleared");

endmodule
